@@ hw/rtl/lpht_pkg.sv @@
// Shared constants, operation and status codes, and the command/status
// structs that join the hash table controller to its datapath.
// No dependencies.
package lpht_pkg;

    localparam int LPHT_SLOT_COUNT = 8;

    localparam int KEY_W       = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_OUT_W  = 3;
    localparam int OUT_TDATA_W = 8;

    // home slot is worked out a few key bits per cycle
    localparam int HASH_BITS  = 4;
    localparam int HASH_STEPS = KEY_W / HASH_BITS;
    localparam int HCNT_W     = $clog2(HASH_STEPS);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STS_ZERO_KEY = 2'd3;

    typedef struct packed {
        logic                load;
        logic                hash_step;
        logic                advance;
        logic                mem_wr;
        logic                wr_key;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
    } lpht_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic              in_key_zero;
        logic              clr_last;
        logic              hash_last;
        logic              slot_empty;
        logic              slot_match;
        logic              probe_last;
        logic              out_free;
    } lpht_stat_t;

endpackage

@@ hw/rtl/lpht_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hw/rtl/lpht_dp.sv @@
// Hash table datapath: key and home-slot registers, probe address and
// count, slot store and result register. Depends on lpht_pkg, lpht_ram.
module lpht_dp import lpht_pkg::*; #(
    parameter int SLOT_COUNT = LPHT_SLOT_COUNT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lpht_cmd_t             cmd,
    output lpht_stat_t            stat,
    input  logic [KIND_W-1:0]     in_kind,
    input  logic [KEY_W-1:0]      in_key,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   out_status,
    output logic [SLOT_OUT_W-1:0] out_slot
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int REM_W = IDX_W + 1;
    localparam logic [REM_W-1:0] MOD_N    = REM_W'(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    logic [KEY_W-1:0]      key_reg,    key_next;
    logic [KEY_W-1:0]      shift_reg,  shift_next;
    logic [IDX_W-1:0]      rem_reg,    rem_next;
    logic [HCNT_W-1:0]     hcnt_reg,   hcnt_next;
    logic [IDX_W-1:0]      addr_reg,   addr_next;
    logic [IDX_W-1:0]      pcnt_reg,   pcnt_next;
    logic                  valid_reg,  valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_OUT_W-1:0] slot_reg,   slot_next;

    logic [REM_W-1:0] hash_acc;
    logic [IDX_W-1:0] rem_new;
    logic [IDX_W-1:0] addr_inc;
    logic [KEY_W-1:0] wr_data;
    logic [KEY_W-1:0] rd_data;

    // fold the next few key bits into the running remainder
    always_comb
    begin
        hash_acc = {1'b0, rem_reg};
        for (int i = 0; i < HASH_BITS; i++)
        begin
            hash_acc = {hash_acc[IDX_W-1:0], shift_reg[KEY_W-1-i]};
            if (hash_acc >= MOD_N)
            begin
                hash_acc = hash_acc - MOD_N;
            end
        end
        rem_new = hash_acc[IDX_W-1:0];
    end

    assign addr_inc = (addr_reg == LAST_IDX) ? '0 : addr_reg + 1'b1;
    assign wr_data  = cmd.wr_key ? key_reg : '0;

    always_comb
    begin
        key_next    = key_reg;
        shift_next  = shift_reg;
        rem_next    = rem_reg;
        hcnt_next   = hcnt_reg;
        addr_next   = addr_reg;
        pcnt_next   = pcnt_reg;
        valid_next  = valid_reg;
        status_next = status_reg;
        slot_next   = slot_reg;

        if (cmd.load)
        begin
            key_next   = in_key;
            shift_next = in_key;
            rem_next   = '0;
            hcnt_next  = '0;
            pcnt_next  = '0;
        end
        if (cmd.hash_step)
        begin
            shift_next = shift_reg << HASH_BITS;
            rem_next   = rem_new;
            hcnt_next  = hcnt_reg + 1'b1;
            addr_next  = rem_new;
        end
        if (cmd.advance)
        begin
            addr_next = addr_inc;
            pcnt_next = pcnt_reg + 1'b1;
        end

        if (cmd.res_load)
        begin
            valid_next  = 1'b1;
            status_next = cmd.res_status;
            slot_next   = (cmd.res_status == STS_OK) ? SLOT_OUT_W'(addr_reg) : '0;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg  <= addr_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        hcnt_reg   <= hcnt_next;
        pcnt_reg   <= pcnt_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // read address follows the next probe address, so the registered read data
    // always belongs to the current addr_reg
    lpht_ram #(
        .WIDTH (KEY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk     (clk),
        .wr_en   (cmd.mem_wr),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_addr (addr_next),
        .rd_data (rd_data)
    );

    assign stat.in_kind     = in_kind;
    assign stat.in_key_zero = (in_key == '0);
    assign stat.clr_last    = (addr_reg == LAST_IDX);
    assign stat.hash_last   = (hcnt_reg == HCNT_W'(HASH_STEPS - 1));
    assign stat.slot_empty  = (rd_data == '0);
    assign stat.slot_match  = (rd_data == key_reg);
    assign stat.probe_last  = (pcnt_reg == LAST_IDX);
    assign stat.out_free    = !valid_reg || out_ready;

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_slot   = slot_reg;

endmodule

@@ hw/rtl/lpht_ctrl.sv @@
// Hash table controller: clearing pass, hashing, probe sequencing and
// result hand-off. Depends on lpht_pkg.
module lpht_ctrl import lpht_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  lpht_stat_t stat,
    output lpht_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [KIND_W-1:0]   op_reg,    op_next;
    logic [STATUS_W-1:0] res_reg,   res_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.advance = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next  = stat.in_kind;
                    if (stat.in_kind inside {KIND_INSERT, KIND_SEARCH, KIND_DELETE})
                    begin
                        if (stat.in_key_zero)
                        begin
                            res_next   = STS_ZERO_KEY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_HASH;
                        end
                    end
                    else
                    begin
                        res_next   = STS_MISSING;
                        state_next = S_DONE;
                    end
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (op_reg == KIND_INSERT)
                begin
                    if (stat.slot_empty)
                    begin
                        cmd.mem_wr = 1'b1;
                        cmd.wr_key = 1'b1;
                        res_next   = STS_OK;
                        state_next = S_DONE;
                    end
                    else if (stat.probe_last)
                    begin
                        res_next   = STS_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
                else
                begin
                    if (stat.slot_empty)
                    begin
                        res_next   = STS_MISSING;
                        state_next = S_DONE;
                    end
                    else if (stat.slot_match)
                    begin
                        // delete empties the slot it found
                        cmd.mem_wr = (op_reg == KIND_DELETE);
                        res_next   = STS_OK;
                        state_next = S_DONE;
                    end
                    else if (stat.probe_last)
                    begin
                        res_next   = STS_MISSING;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
    end

endmodule

@@ hw/rtl/linear_probe_hash_table_top.sv @@
// Linear-probing hash table of 32-bit keys, top level.
// Slave word: tuser carries the operation (insert, search, delete), tdata the key.
// Master word: tuser carries the status, tdata the slot index (zero padded).
// After reset the slot store is cleared, one slot per cycle; s_axis_tready
// stays low during that pass.
// One operation at a time: an accepted word first forms its home slot (4 key bits
// per cycle, remainder by compare and subtract), then probes 1 to SLOT_COUNT
// slots, each a read of the slot RAM, then loads the result register. Key zero
// and unused operations skip hashing and probing and go straight to the result.
// The next word can be taken in the cycle after the result is loaded, while that
// result may still wait in the output register; no new word is taken before then.
// If the receiver stalls with a result waiting, the following operation
// completes its probe and holds until the output register frees; nothing is
// dropped.
// Depends on lpht_pkg, lpht_ctrl, lpht_dp, lpht_ram.
module linear_probe_hash_table_top import lpht_pkg::*; #(
    parameter int SLOT_COUNT = LPHT_SLOT_COUNT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_W-1:0]       s_axis_tdata,   // [31:0] key
    input  logic [KIND_W-1:0]      s_axis_tuser,   // [1:0] kind
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [2:0] slot_index, [7:3] zero
    output logic [STATUS_W-1:0]    m_axis_tuser    // [1:0] status
);

    lpht_cmd_t             cmd;
    lpht_stat_t            stat;
    logic [SLOT_OUT_W-1:0] out_slot;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpht_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_kind    (s_axis_tuser),
        .in_key     (s_axis_tdata),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_slot   (out_slot)
    );

    assign m_axis_tdata = OUT_TDATA_W'(out_slot);

endmodule

@@ tb/sv/linear_probe_hash_table_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for linear_probe_hash_table_top: drives insert, search and
// delete words with bursty input and a stalling receiver; checks every result word.
// Depends on lpht_pkg and the linear_probe_hash_table_top RTL.
module linear_probe_hash_table_top_test import lpht_pkg::*; ();

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_WORDS  = 1600;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_EVERY   = 400;
    localparam int KEY_POOL_SIZE = 12;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
    } lookup_result_t;

    // Shadow copy of the slot store and the results still owed by the block.
    class hash_scoreboard;
        logic [KEY_W-1:0] slot_keys [LPHT_SLOT_COUNT];
        lookup_result_t   owed_q [$];
        int               errors;

        function new();
            foreach (slot_keys[i])
                slot_keys[i] = '0;
            errors = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Any key currently stored, or zero when the store is empty.
        function logic [KEY_W-1:0] stored_key();
            logic [KEY_W-1:0] found [$];
            foreach (slot_keys[i])
                if (slot_keys[i] != '0)
                    found.push_back(slot_keys[i]);
            if (found.size() == 0)
                return '0;
            return found[$urandom_range(0, found.size() - 1)];
        endfunction

        function void note_word(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
            lookup_result_t r;
            int unsigned    pos;
            r.status = STS_MISSING;
            r.slot   = '0;
            pos      = key % LPHT_SLOT_COUNT;
            if (kind != KIND_UNUSED && key == '0)
            begin
                r.status = STS_ZERO_KEY;
            end
            else if (kind == KIND_INSERT)
            begin
                r.status = STS_FULL;
                for (int n = 0; n < LPHT_SLOT_COUNT; n++)
                begin
                    if (slot_keys[pos] == '0)
                    begin
                        slot_keys[pos] = key;
                        r.status = STS_OK;
                        r.slot   = pos[SLOT_OUT_W-1:0];
                        break;
                    end
                    pos = (pos + 1) % LPHT_SLOT_COUNT;
                end
            end
            else if (kind == KIND_SEARCH || kind == KIND_DELETE)
            begin
                // stop at the first hole: no tombstones are kept
                for (int n = 0; n < LPHT_SLOT_COUNT; n++)
                begin
                    if (slot_keys[pos] == '0)
                        break;
                    if (slot_keys[pos] == key)
                    begin
                        if (kind == KIND_DELETE)
                            slot_keys[pos] = '0;
                        r.status = STS_OK;
                        r.slot   = pos[SLOT_OUT_W-1:0];
                        break;
                    end
                    pos = (pos + 1) % LPHT_SLOT_COUNT;
                end
            end
            owed_q.push_back(r);
        endfunction

        function void check_word(logic [STATUS_W-1:0] status, logic [OUT_TDATA_W-1:0] data);
            lookup_result_t exp_r;
            if (owed_q.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none owed: status %0d tdata %0h",
                         $realtime, status, data);
                return;
            end
            exp_r = owed_q.pop_front();
            if (status !== exp_r.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $realtime, exp_r.status, status);
            end
            if (data !== OUT_TDATA_W'(exp_r.slot))
            begin
                errors++;
                $display("%0t: slot_index mismatch: expected %0h, actual %0h",
                         $realtime, OUT_TDATA_W'(exp_r.slot), data);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [KEY_W-1:0]       s_axis_tdata = '0;
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]    m_axis_tuser;

    hash_scoreboard   sb = new();
    int               stalled_cycles = 0;
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    linear_probe_hash_table_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Check the result word before noting a new input on the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tuser, s_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("FAIL linear_probe_hash_table_top");
            $finish;
        end
    end

    // Receiver back-pressure: switch between stall patterns at random.
    initial
    begin
        int mode;
        int hold_left;
        mode      = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 99) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        m_axis_tready <= 1'b1;
                        hold_left = $urandom_range(5, 30);
                    end
                    else
                    begin
                        m_axis_tready <= 1'b0;
                        hold_left--;
                    end
                end
            endcase
        end
    end

    // Present one word and hold it until the block takes it.
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= key;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= KIND_W'($urandom_range(0, 3));
        s_axis_tdata  <= $urandom;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [KEY_W-1:0] fresh_pool_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        if (k == '0)
            k = KEY_W'(LPHT_SLOT_COUNT);
        return k;
    endfunction

    // Random operation; the phase sets whether inserts or deletes dominate.
    task automatic make_op(input int phase, output logic [KIND_W-1:0] kind,
                           output logic [KEY_W-1:0] key);
        int r;
        int ins_weight;
        logic [KEY_W-1:0] held;
        r          = $urandom_range(0, 99);
        ins_weight = (phase == 0) ? 60 : (phase == 1) ? 35 : 15;
        if (r < 2)
        begin
            kind = KIND_UNUSED;
            key  = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
            return;
        end
        if (r < 5)
        begin
            kind = KIND_W'($urandom_range(0, 2));
            key  = '0;
            return;
        end
        r = $urandom_range(0, 99);
        if (r < ins_weight)
            kind = KIND_INSERT;
        else if (r < ins_weight + (100 - ins_weight) / 2)
            kind = KIND_SEARCH;
        else
            kind = KIND_DELETE;
        r = $urandom_range(0, 99);
        held = sb.stored_key();
        if (kind != KIND_INSERT && r < 60 && held != '0)
            key = held;
        else if (r < 88)
            key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        else
            key = fresh_pool_key();
    endtask

    initial
    begin
        logic [KIND_W-1:0] d_kind [$];
        logic [KEY_W-1:0]  d_key [$];
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        int sent;
        int burst;
        int gap;
        int next_drain;

        // zero key per kind, unused kind, then fill slots with wrapping runs
        d_kind = '{KIND_INSERT, KIND_SEARCH, KIND_DELETE, KIND_UNUSED, KIND_SEARCH,
                   KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_INSERT,
                   KIND_INSERT, KIND_INSERT, KIND_INSERT, KIND_INSERT,
                   KIND_INSERT, KIND_SEARCH, KIND_SEARCH, KIND_DELETE,
                   KIND_SEARCH, KIND_INSERT, KIND_DELETE, KIND_SEARCH,
                   KIND_DELETE, KIND_UNUSED};
        d_key  = '{32'h0, 32'h0, 32'h0, 32'h5, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'h7, 32'hF, 32'h8,
                   32'h8000_0000, 32'h1234_5678, 32'h3, 32'h7FFF_FFFF,
                   32'h1, 32'hF, 32'h1, 32'h7,
                   32'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h5555_5555, 32'h0};

        foreach (key_pool[i])
            key_pool[i] = fresh_pool_key();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (d_kind[i])
        begin
            send_word(d_kind[i], d_key[i]);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 6));
        end
        wait_for_results();

        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_WORDS)
        begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_WORDS; j++)
            begin
                make_op((sent / 100) % 3, kind, key);
                send_word(kind, key);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = fresh_pool_key();
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(20, 40);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0)
                idle_sender(gap);
            if (sent >= next_drain)
            begin
                wait_for_results();
                next_drain += DRAIN_EVERY;
            end
        end

        wait_for_results();
        repeat (LPHT_SLOT_COUNT + 30) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS linear_probe_hash_table_top");
        else
            $display("FAIL linear_probe_hash_table_top");
        $finish;
    end

endmodule
